// File: hw/rtl/dcp_pkg.sv
// Shared types and constants of the distance constraint projection block.
`default_nettype none

package dcp_pkg;

	// Index reduction modulus; a power of two at or above 4096 leaves indices as they are.
	localparam int MAX_PARTICLES = 4096;

	// Configuration port geometry: one 32-bit register at byte address 0.
	localparam int ADDR_W = 3;
	localparam logic [0:0] REG_ALPHA = 1'b0;

	// Internal magnitudes: difference, length and denominator all fit in 33 bits.
	localparam int VW = 33;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_LEN = 2'd1,
		ST_ZERO_DEN = 2'd2,
		ST_SAT      = 2'd3
	} status_t;

	typedef struct packed {
		logic [11:0]        index_first;
		logic [11:0]        index_second;
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
		logic [23:0]        weight_first;
		logic [23:0]        weight_second;
		logic [30:0]        rest_length;
	} item_t;

	typedef struct packed {
		logic [11:0]        out_index_first;
		logic [11:0]        out_index_second;
		logic signed [31:0] new_first_x;
		logic signed [31:0] new_first_y;
		logic signed [31:0] new_first_z;
		logic signed [31:0] new_second_x;
		logic signed [31:0] new_second_y;
		logic signed [31:0] new_second_z;
		status_t            status;
	} result_t;

	// Side data that rides along the square root pipeline.
	typedef struct packed {
		logic [11:0]          idx_first;
		logic [11:0]          idx_second;
		logic [2:0][31:0]     pos_first;
		logic [2:0][31:0]     pos_second;
		logic [2:0][VW-1:0]   diff;
		logic [23:0]          w_first;
		logic [23:0]          w_second;
		logic [30:0]          rest;
		logic [VW-1:0]        den;
	} side_t;

	// Side data that rides along the divider pipelines.
	typedef struct packed {
		logic [11:0]      idx_first;
		logic [11:0]      idx_second;
		logic [2:0][31:0] pos_first;
		logic [2:0][31:0] pos_second;
		logic             zero_len;
		logic             zero_den;
	} post_t;

endpackage

`default_nettype wire

// File: hw/rtl/dcp_isqrt.sv
// Pipelined floor square root, one result bit per stage.
`default_nettype none

module dcp_isqrt
	import dcp_pkg::*;
#(
	parameter int RW = 33,
	parameter int TW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [2*RW-1:0] rad,
	input  logic [TW-1:0]   in_tag,
	output logic            out_vld,
	output logic [RW-1:0]   root,
	output logic [TW-1:0]   out_tag
);

	localparam int XW = 2*RW + 1;

	logic [XW-1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [TW-1:0] tag_s  [RW];
	logic          vld_s  [RW];

	for (genvar i = 0; i < RW; i++) begin : g_stage
		localparam int B = RW - 1 - i;
		logic [XW-1:0] rem_p;
		logic [RW-1:0] root_p;
		logic [TW-1:0] tag_p;
		logic          vld_p;
		logic [XW-1:0] trial;
		logic          take;

		if (i == 0) begin : g_first
			assign rem_p  = XW'(rad);
			assign root_p = '0;
			assign tag_p  = in_tag;
			assign vld_p  = in_vld;
		end else begin : g_next
			assign rem_p  = rem_s[i-1];
			assign root_p = root_s[i-1];
			assign tag_p  = tag_s[i-1];
			assign vld_p  = vld_s[i-1];
		end

		// (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
		assign trial = (XW'(root_p) << (B + 1)) + (XW'(1) << (2*B));
		assign take  = (rem_p >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= take ? (rem_p - trial) : rem_p;
				root_s[i] <= take ? (root_p | (RW'(1) << B)) : root_p;
				tag_s[i]  <= tag_p;
			end
		end
	end

	assign out_vld = vld_s[RW-1];
	assign root    = root_s[RW-1];
	assign out_tag = tag_s[RW-1];

endmodule

`default_nettype wire

// File: hw/rtl/dcp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module dcp_div
	import dcp_pkg::*;
#(
	parameter int NW = 57,
	parameter int DW = 33,
	parameter int QW = 33,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	input  logic [TW-1:0] in_tag,
	output logic          out_vld,
	output logic [QW-1:0] quot,
	output logic [TW-1:0] out_tag
);

	localparam int W = (NW > DW + QW) ? NW : DW + QW;

	logic [W-1:0]  rem_s [QW];
	logic [DW-1:0] dvs_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [TW-1:0] tag_s [QW];
	logic          vld_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int B = QW - 1 - i;
		logic [W-1:0]  rem_p;
		logic [DW-1:0] dvs_p;
		logic [QW-1:0] quo_p;
		logic [TW-1:0] tag_p;
		logic          vld_p;
		logic [W-1:0]  trial;
		logic          take;

		if (i == 0) begin : g_first
			assign rem_p = W'(dividend);
			assign dvs_p = divisor;
			assign quo_p = '0;
			assign tag_p = in_tag;
			assign vld_p = in_vld;
		end else begin : g_next
			assign rem_p = rem_s[i-1];
			assign dvs_p = dvs_s[i-1];
			assign quo_p = quo_s[i-1];
			assign tag_p = tag_s[i-1];
			assign vld_p = vld_s[i-1];
		end

		assign trial = W'(dvs_p) << B;
		assign take  = (rem_p >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? (rem_p - trial) : rem_p;
				dvs_s[i] <= dvs_p;
				quo_s[i] <= take ? (quo_p | (QW'(1) << B)) : quo_p;
				tag_s[i] <= tag_p;
			end
		end
	end

	assign out_vld = vld_s[QW-1];
	assign quot    = quo_s[QW-1];
	assign out_tag = tag_s[QW-1];

endmodule

`default_nettype wire

// File: hw/rtl/distance_constraint_project_core.sv
// Top level of the distance constraint projection pipeline.
`default_nettype none

// Channel  | Direction | Handshake                   | Word
// ---------+-----------+-----------------------------+----------------------------
// item     | in        | item_valid / item_ready     | item_t: two positions, weights
// result   | out       | result_valid / result_ready | result_t: new positions, status
// config   | in        | psel/penable/pwrite, pready | compliance_alpha at byte 0
//
// One word enters per cycle while the pipeline is not held; each result passes through
// the 33-stage square root and the 33-stage dividers in series.
// All stages advance together: when the output register holds an untaken
// word, the whole pipeline holds and item_ready drops.
// Reset clears the valid bits and compliance_alpha; payload is not reset.

module distance_constraint_project_core
	import dcp_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int UW  = VW + FRAC_BITS;     // scaled difference for the unit vector
	localparam int PW  = VW + 24;            // |C| times weight
	localparam int MW  = VW + FRAC_BITS + 1; // |s| times |u|
	localparam int DMW = MW - FRAC_BITS;     // correction magnitude
	localparam int NWW = DMW + 2;            // new coordinate before saturation

	// ---------------------------------------------------------------------
	// Configuration register
	// ---------------------------------------------------------------------
	logic [31:0] alpha_q;
	logic [0:0]  reg_idx;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_ALPHA) ? alpha_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
		end else if (psel && penable && pwrite && (reg_idx == REG_ALPHA)) begin
			alpha_q <= pwdata;
		end
	end

	// ---------------------------------------------------------------------
	// Global advance: move every stage unless the output word is stuck
	// ---------------------------------------------------------------------
	logic    en;
	logic    result_valid_q;
	result_t result_q;

	assign en           = !result_valid_q || result_ready;
	assign item_ready   = en;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	function automatic logic [VW-1:0] mag33(input logic [VW-1:0] v);
		mag33 = v[VW-1] ? (VW'(0) - v) : v;
	endfunction

	// ---------------------------------------------------------------------
	// Stage 1: differences, denominator, index reduction
	// ---------------------------------------------------------------------
	logic  vld_s1;
	side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.idx_first  <= 12'(32'(item.index_first) % MAX_PARTICLES);
			side_s1.idx_second <= 12'(32'(item.index_second) % MAX_PARTICLES);
			side_s1.pos_first  <= {item.first_z, item.first_y, item.first_x};
			side_s1.pos_second <= {item.second_z, item.second_y, item.second_x};
			side_s1.diff[0]    <= VW'(item.first_x) - VW'(item.second_x);
			side_s1.diff[1]    <= VW'(item.first_y) - VW'(item.second_y);
			side_s1.diff[2]    <= VW'(item.first_z) - VW'(item.second_z);
			side_s1.w_first    <= item.weight_first;
			side_s1.w_second   <= item.weight_second;
			side_s1.rest       <= item.rest_length;
			side_s1.den        <= VW'(item.weight_first) + VW'(item.weight_second)
				+ VW'(alpha_q);
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: squares of the difference magnitudes
	// ---------------------------------------------------------------------
	logic                  vld_s2;
	side_t                 side_s2;
	logic [2:0][2*VW-1:0]  sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= (2*VW)'(mag33(side_s1.diff[k])) * (2*VW)'(mag33(side_s1.diff[k]));
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: squared length (below 3 * 2^64, fits 66 bits)
	// ---------------------------------------------------------------------
	logic              vld_s3;
	side_t             side_s3;
	logic [2*VW-1:0]   rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			rad_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	// ---------------------------------------------------------------------
	// Square root: 33 stages, side data rides as tag
	// ---------------------------------------------------------------------
	logic                     rt_vld;
	logic [VW-1:0]            rt_len;
	logic [$bits(side_t)-1:0] rt_tag;
	side_t                    rt_side;

	dcp_isqrt #(
		.RW (VW),
		.TW ($bits(side_t))
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s3),
		.rad     (rad_s3),
		.in_tag  (side_s3),
		.out_vld (rt_vld),
		.root    (rt_len),
		.out_tag (rt_tag)
	);

	assign rt_side = side_t'(rt_tag);

	// ---------------------------------------------------------------------
	// Stage 4: constraint error C = d - rest, guards
	// ---------------------------------------------------------------------
	logic          vld_s4;
	side_t         side_s4;
	logic [VW-1:0] len_s4;
	logic [VW-1:0] cmag_s4;
	logic          cneg_s4;
	logic          zlen_s4;
	logic          zden_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= rt_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= rt_side;
			len_s4  <= rt_len;
			cneg_s4 <= (rt_len < VW'(rt_side.rest));
			cmag_s4 <= (rt_len < VW'(rt_side.rest)) ? (VW'(rt_side.rest) - rt_len)
				: (rt_len - VW'(rt_side.rest));
			zlen_s4 <= (rt_len == '0);
			zden_s4 <= (rt_side.den == '0);
		end
	end

	// ---------------------------------------------------------------------
	// Stage 5: divider operands
	// ---------------------------------------------------------------------
	logic            vld_s5;
	post_t           post_s5;
	logic [PW-1:0]   prod1_s5;
	logic [PW-1:0]   prod2_s5;
	logic            cneg_s5;
	logic [VW-1:0]   len_s5;
	logic [VW-1:0]   den_s5;
	logic [2:0][UW-1:0] ud_s5;
	logic [2:0]      dneg_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			post_s5.idx_first  <= side_s4.idx_first;
			post_s5.idx_second <= side_s4.idx_second;
			post_s5.pos_first  <= side_s4.pos_first;
			post_s5.pos_second <= side_s4.pos_second;
			post_s5.zero_len   <= zlen_s4;
			post_s5.zero_den   <= zden_s4;
			prod1_s5 <= PW'(cmag_s4) * PW'(side_s4.w_first);
			prod2_s5 <= PW'(cmag_s4) * PW'(side_s4.w_second);
			cneg_s5  <= cneg_s4;
			len_s5   <= len_s4;
			den_s5   <= side_s4.den;
			for (int k = 0; k < 3; k++) begin
				ud_s5[k]   <= UW'(mag33(side_s4.diff[k])) << FRAC_BITS;
				dneg_s5[k] <= side_s4.diff[k][VW-1];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Dividers: |s_i| = |C| w_i / den and |u_k| = |diff_k| 2^F / d
	// ---------------------------------------------------------------------
	logic                     dv_vld;
	logic [VW-1:0]            qs1;
	logic [VW-1:0]            qs2;
	logic [$bits(post_t)-1:0] dv_tag;
	logic                     dv_cneg;
	logic [2:0][VW-1:0]       qu;
	logic [2:0]               dv_dneg;

	dcp_div #(
		.NW (PW),
		.DW (VW),
		.QW (VW),
		.TW ($bits(post_t))
	) u_div_s1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s5),
		.dividend (prod1_s5),
		.divisor  (den_s5),
		.in_tag   (post_s5),
		.out_vld  (dv_vld),
		.quot     (qs1),
		.out_tag  (dv_tag)
	);

	dcp_div #(
		.NW (PW),
		.DW (VW),
		.QW (VW),
		.TW (1)
	) u_div_s2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s5),
		.dividend (prod2_s5),
		.divisor  (den_s5),
		.in_tag   (cneg_s5),
		.out_vld  (),
		.quot     (qs2),
		.out_tag  (dv_cneg)
	);

	for (genvar k = 0; k < 3; k++) begin : g_udiv
		dcp_div #(
			.NW (UW),
			.DW (VW),
			.QW (VW),
			.TW (1)
		) u_div_u (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (vld_s5),
			.dividend (ud_s5[k]),
			.divisor  (len_s5),
			.in_tag   (dneg_s5[k]),
			.out_vld  (),
			.quot     (qu[k]),
			.out_tag  (dv_dneg[k])
		);
	end

	// ---------------------------------------------------------------------
	// Stage 6: |s_i| * |u_k| (|u_k| <= 2^F)
	// ---------------------------------------------------------------------
	logic              vld_s6;
	post_t             post_s6;
	logic [2:0][MW-1:0] m1_s6;
	logic [2:0][MW-1:0] m2_s6;
	logic [2:0]        neg_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			post_s6 <= post_t'(dv_tag);
			for (int k = 0; k < 3; k++) begin
				m1_s6[k]  <= MW'(qs1) * MW'(qu[k][FRAC_BITS:0]);
				m2_s6[k]  <= MW'(qs2) * MW'(qu[k][FRAC_BITS:0]);
				neg_s6[k] <= dv_cneg ^ dv_dneg[k];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stage 7: apply corrections, first moves against lambda, second with it
	// ---------------------------------------------------------------------
	logic                       vld_s7;
	post_t                      post_s7;
	logic [2:0][NWW-1:0]        new1_s7;
	logic [2:0][NWW-1:0]        new2_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			post_s7 <= post_s6;
			for (int k = 0; k < 3; k++) begin
				new1_s7[k] <= neg_s6[k]
					? (NWW'($signed(post_s6.pos_first[k])) + NWW'(m1_s6[k][MW-1:FRAC_BITS]))
					: (NWW'($signed(post_s6.pos_first[k])) - NWW'(m1_s6[k][MW-1:FRAC_BITS]));
				new2_s7[k] <= neg_s6[k]
					? (NWW'($signed(post_s6.pos_second[k])) - NWW'(m2_s6[k][MW-1:FRAC_BITS]))
					: (NWW'($signed(post_s6.pos_second[k])) + NWW'(m2_s6[k][MW-1:FRAC_BITS]));
			end
		end
	end

	// ---------------------------------------------------------------------
	// Output register: saturate, pick status, pass through on a guard
	// ---------------------------------------------------------------------
	function automatic logic [32:0] sat32(input logic [NWW-1:0] v);
		logic neg;
		logic fits;
		neg  = v[NWW-1];
		fits = (v[NWW-1:31] == '0) || (v[NWW-1:31] == '1);
		if (fits) begin
			sat32 = {1'b0, v[31:0]};
		end else if (neg) begin
			sat32 = {1'b1, 32'h8000_0000};
		end else begin
			sat32 = {1'b1, 32'h7FFF_FFFF};
		end
	endfunction

	logic [2:0][32:0] s1_sat;
	logic [2:0][32:0] s2_sat;
	logic             any_sat;
	result_t          res_d;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			s1_sat[k] = sat32(new1_s7[k]);
			s2_sat[k] = sat32(new2_s7[k]);
		end
		any_sat = s1_sat[0][32] | s1_sat[1][32] | s1_sat[2][32]
			| s2_sat[0][32] | s2_sat[1][32] | s2_sat[2][32];

		res_d.out_index_first  = post_s7.idx_first;
		res_d.out_index_second = post_s7.idx_second;
		if (post_s7.zero_len || post_s7.zero_den) begin
			res_d.new_first_x  = post_s7.pos_first[0];
			res_d.new_first_y  = post_s7.pos_first[1];
			res_d.new_first_z  = post_s7.pos_first[2];
			res_d.new_second_x = post_s7.pos_second[0];
			res_d.new_second_y = post_s7.pos_second[1];
			res_d.new_second_z = post_s7.pos_second[2];
			res_d.status       = post_s7.zero_len ? ST_ZERO_LEN : ST_ZERO_DEN;
		end else begin
			res_d.new_first_x  = s1_sat[0][31:0];
			res_d.new_first_y  = s1_sat[1][31:0];
			res_d.new_first_z  = s1_sat[2][31:0];
			res_d.new_second_x = s2_sat[0][31:0];
			res_d.new_second_y = s2_sat[1][31:0];
			res_d.new_second_z = s2_sat[2][31:0];
			res_d.status       = any_sat ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en) begin
			result_valid_q <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= res_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/dcp_checker.sv
// Port-level checks for the distance constraint projection core, with bind.
`default_nettype none

module dcp_checker
	import dcp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input item_t             item,
	input logic              result_valid,
	input logic              result_ready,
	input result_t           result,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [31:0]       pwdata,
	input logic [31:0]       prdata,
	input logic              pready
);

	// Hold a stalled result word.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// Accept input exactly when the output is free to move.
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready == (!result_valid || result_ready))
		else $error("item_ready does not follow output stall");

	// A zero-length constraint reports two identical positions.
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_ZERO_LEN) |->
		(result.new_first_x == result.new_second_x) &&
		(result.new_first_y == result.new_second_y) &&
		(result.new_first_z == result.new_second_z))
		else $error("zero-length result with differing positions");

	// Read back the register just written.
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_ALPHA)) ##1
		(psel && !pwrite && (paddr[ADDR_W-1:2] == REG_ALPHA)) |->
		prdata == $past(pwdata))
		else $error("compliance_alpha readback mismatch");

endmodule

bind distance_constraint_project_core dcp_checker u_dcp_checker (.*);

`default_nettype wire
